>>> design/fpi_pkg.sv
// ----------------------------------------------------------------------------
// fpi_pkg: shared types and constants of the point interpolator
// Law and status codes, pipeline depths and the control structs that travel
// with each request.
// ----------------------------------------------------------------------------
`default_nettype none

package fpi_pkg;

  localparam int DATA_W   = 32;
  localparam int LOG_FRAC = 56;
  localparam int LOG_IW   = 5;
  localparam int LOG_W    = LOG_FRAC + LOG_IW;
  localparam int LOG_LAT  = 1 + 2 * LOG_FRAC;

  localparam int NUM_OPND = 5;
  localparam int OPND_X   = 0;
  localparam int OPND_X1  = 1;
  localparam int OPND_X2  = 2;
  localparam int OPND_Y1  = 3;
  localparam int OPND_Y2  = 4;

  localparam int WT_W      = 33;
  localparam int DIV_STEPS = 32;
  localparam int DIV_W     = LOG_W + 1;
  localparam int DIV_LAT   = 2 + DIV_STEPS;

  localparam int EXP_TERMS  = 24;
  localparam int EXP_ITERS  = EXP_TERMS - 1;
  localparam int RCP_STAGES = 3;
  localparam int ITER_LAT   = 2 + RCP_STAGES;
  localparam int EXP_LAT    = 6 + EXP_ITERS * ITER_LAT + 2;

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

  typedef enum logic [2:0] {
    LAW_LINLIN = 3'd0,
    LAW_LOGLIN = 3'd1,
    LAW_LINLOG = 3'd2,
    LAW_LOGLOG = 3'd3,
    LAW_FLAT   = 3'd4,
    LAW_OTHER  = 3'd5
  } law_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OTHER   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic                     done;
    status_t                  st;
    logic signed [DATA_W-1:0] spec_y;
    logic                     log_wt;
    logic                     use_exp;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] y2;
    logic [DATA_W-1:0]        lin_a;
    logic [DATA_W-1:0]        lin_d;
  } side_t;

  typedef struct packed {
    side_t            sd;
    logic [LOG_W-1:0] ly1;
    logic [LOG_W-1:0] ly2;
  } mid_t;

  typedef struct packed {
    logic                     done;
    status_t                  st;
    logic signed [DATA_W-1:0] spec_y;
    logic                     use_exp;
  } ctl_t;

endpackage

`default_nettype wire

>>> design/fpi_log_bank.sv
// ----------------------------------------------------------------------------
// fpi_log_bank: five parallel base-2 log pipelines
// Each lane normalizes its operand, then squares the mantissa once per
// result bit, two stages per bit (partial products, then sum).
// ----------------------------------------------------------------------------
`default_nettype none

module fpi_log_bank import fpi_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_in,
  input  side_t                             sd_in,
  input  logic [NUM_OPND-1:0][DATA_W-1:0]   opnd,
  output logic                              vld_out,
  output side_t                             sd_out,
  output logic [NUM_OPND-1:0][LOG_W-1:0]    lg
);

  logic [LOG_LAT-1:0] vld_r;
  side_t              sd_r [LOG_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LOG_LAT-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= sd_in;
      for (int i = 1; i < LOG_LAT; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  assign vld_out = vld_r[LOG_LAT-1];
  assign sd_out  = sd_r[LOG_LAT-1];

  for (genvar l = 0; l < NUM_OPND; l++) begin : g_lane
    logic [63:0]         z_r    [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] acc_r  [LOG_FRAC+1];
    logic [LOG_IW-1:0]   k_r    [LOG_FRAC+1];
    logic                zero_r [LOG_FRAC+1];
    logic [63:0]         p11_r  [LOG_FRAC];
    logic [63:0]         p01_r  [LOG_FRAC];
    logic [63:0]         p00_r  [LOG_FRAC];
    logic [LOG_FRAC-1:0] acca_r [LOG_FRAC];
    logic [LOG_IW-1:0]   ka_r   [LOG_FRAC];
    logic                zeroa_r[LOG_FRAC];

    logic [LOG_IW-1:0] top_k;
    logic [5:0]        sh;
    logic [63:0]       z0;

    always_comb begin
      top_k = '0;
      for (int i = 0; i < DATA_W; i++) begin
        if (opnd[l][i]) top_k = LOG_IW'(i);
      end
      sh = 6'd63 - {1'b0, top_k};
      z0 = {32'b0, opnd[l]} << sh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[0]    <= z0;
        acc_r[0]  <= '0;
        k_r[0]    <= top_k;
        zero_r[0] <= (opnd[l] == '0);
      end
    end

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_bit
      logic [127:0] sq;

      always_ff @(posedge clk) begin
        if (en) begin
          p11_r[j]   <= z_r[j][63:32] * z_r[j][63:32];
          p01_r[j]   <= z_r[j][63:32] * z_r[j][31:0];
          p00_r[j]   <= z_r[j][31:0] * z_r[j][31:0];
          acca_r[j]  <= acc_r[j];
          ka_r[j]    <= k_r[j];
          zeroa_r[j] <= zero_r[j];
        end
      end

      // cross term appears twice, hence the shift by 33
      assign sq = {p11_r[j], 64'b0} + {31'b0, p01_r[j], 33'b0} + {64'b0, p00_r[j]};

      always_ff @(posedge clk) begin
        if (en) begin
          z_r[j+1]    <= sq[127] ? sq[127:64] : sq[126:63];
          acc_r[j+1]  <= {acca_r[j][LOG_FRAC-2:0], sq[127]};
          k_r[j+1]    <= ka_r[j];
          zero_r[j+1] <= zeroa_r[j];
        end
      end
    end

    assign lg[l] = zero_r[LOG_FRAC] ? '0 : {k_r[LOG_FRAC], acc_r[LOG_FRAC]};
  end

endmodule

`default_nettype wire

>>> design/fpi_divider.sv
// ----------------------------------------------------------------------------
// fpi_divider: blend weight a/d in Q32
// Picks linear or log distances, handles the saturated and empty cases, then
// runs a restoring divider one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpi_divider import fpi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  mid_t             md_in,
  input  logic [LOG_W-1:0] lx,
  input  logic [LOG_W-1:0] lx1,
  input  logic [LOG_W-1:0] lx2,
  output logic             vld_out,
  output mid_t             md_out,
  output logic [WT_W-1:0]  wt
);

  logic [DIV_LAT-1:0] vld_r;
  mid_t               md_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_LAT-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0] <= md_in;
      for (int i = 1; i < DIV_LAT; i++) md_r[i] <= md_r[i-1];
    end
  end

  assign vld_out = vld_r[DIV_LAT-1];
  assign md_out  = md_r[DIV_LAT-1];

  logic [LOG_W-1:0] la, ld, a_nxt, d_nxt;
  logic [LOG_W-1:0] a0_r, d0_r;

  always_comb begin
    la    = (lx >= lx1) ? lx - lx1 : '0;
    ld    = (lx2 >= lx1) ? lx2 - lx1 : '0;
    a_nxt = md_in.sd.log_wt ? la : LOG_W'(md_in.sd.lin_a);
    d_nxt = md_in.sd.log_wt ? ld : LOG_W'(md_in.sd.lin_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r <= a_nxt;
      d0_r <= d_nxt;
    end
  end

  logic [DIV_W-1:0]     r_r     [DIV_STEPS+1];
  logic [LOG_W-1:0]     d_r     [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_r     [DIV_STEPS+1];
  logic                 fix_r   [DIV_STEPS+1];
  logic                 fixhi_r [DIV_STEPS+1];

  // empty span gives zero, a at or past d gives one
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]     <= {1'b0, a0_r};
      d_r[0]     <= d0_r;
      q_r[0]     <= '0;
      fix_r[0]   <= (d0_r == '0) || (a0_r >= d0_r);
      fixhi_r[0] <= (d0_r != '0);
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [DIV_W-1:0] r2;
    logic             ge;

    assign r2 = {r_r[i][DIV_W-2:0], 1'b0};
    assign ge = (r2 >= {1'b0, d_r[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i+1]     <= ge ? r2 - {1'b0, d_r[i]} : r2;
        d_r[i+1]     <= d_r[i];
        q_r[i+1]     <= {q_r[i][DIV_STEPS-2:0], ge};
        fix_r[i+1]   <= fix_r[i];
        fixhi_r[i+1] <= fixhi_r[i];
      end
    end
  end

  assign wt = fix_r[DIV_STEPS] ? {fixhi_r[DIV_STEPS], {DIV_STEPS{1'b0}}}
                               : {1'b0, q_r[DIV_STEPS]};

endmodule

`default_nettype wire

>>> design/fpi_exp_unit.sv
// ----------------------------------------------------------------------------
// fpi_exp_unit: blends and power of two
// Linear y blend with half-away rounding, log blend, then 2^L by a Taylor
// series: per term one split 64x64 multiply and a reciprocal multiply for the
// divide by the term index.
// ----------------------------------------------------------------------------
`default_nettype none

module fpi_exp_unit import fpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_in,
  input  mid_t                     md_in,
  input  logic [WT_W-1:0]          wt,
  output logic                     vld_out,
  output ctl_t                     ctl_out,
  output logic signed [DATA_W-1:0] ylin,
  output logic [DATA_W-1:0]        yexp
);

  typedef struct packed {
    logic [LOG_IW-1:0] n;
    logic [63:0]       w;
    logic [63:0]       s;
    logic [DATA_W-1:0] ylin;
  } ex_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[64] ? '1 : t[63:0];
  endfunction

  logic [EXP_LAT-1:0] vld_r;
  ctl_t               ctl_r [EXP_LAT];
  ctl_t               ctl_in;

  assign ctl_in = '{done: md_in.sd.done, st: md_in.sd.st, spec_y: md_in.sd.spec_y,
                    use_exp: md_in.sd.use_exp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[EXP_LAT-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < EXP_LAT; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end

  assign vld_out = vld_r[EXP_LAT-1];
  assign ctl_out = ctl_r[EXP_LAT-1];

  // E0: magnitudes
  logic [DATA_W:0]   dy;
  logic [DATA_W:0]   dy_neg;
  logic              up_c;
  logic [DATA_W-1:0] mag_r;
  logic              neg_r, up_r;
  logic [DATA_W-1:0] y1_r;
  logic [LOG_W-1:0]  diff_r, ly1_r;
  logic [WT_W-1:0]   wt_r;

  always_comb begin
    dy     = {md_in.sd.y2[DATA_W-1], md_in.sd.y2} - {md_in.sd.y1[DATA_W-1], md_in.sd.y1};
    dy_neg = -dy;
    up_c   = (md_in.ly2 >= md_in.ly1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= dy[DATA_W];
      mag_r  <= dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
      y1_r   <= md_in.sd.y1;
      up_r   <= up_c;
      diff_r <= up_c ? md_in.ly2 - md_in.ly1 : md_in.ly1 - md_in.ly2;
      ly1_r  <= md_in.ly1;
      wt_r   <= wt;
    end
  end

  // E1: products
  logic [63:0]       yprod1_r, dl1_r;
  logic [LOG_W-1:0]  dh1_r, diff1_r, ly11_r;
  logic              full1_r, neg1_r, up1_r;
  logic [DATA_W-1:0] y11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yprod1_r <= wt_r[WT_W-1] ? {mag_r, 32'b0} : mag_r * wt_r[31:0];
      dh1_r    <= diff_r[LOG_W-1:32] * wt_r[31:0];
      dl1_r    <= diff_r[31:0] * wt_r[31:0];
      full1_r  <= wt_r[WT_W-1];
      diff1_r  <= diff_r;
      neg1_r   <= neg_r;
      y11_r    <= y1_r;
      up1_r    <= up_r;
      ly11_r   <= ly1_r;
    end
  end

  // E2: rounding and delta
  logic [64:0]       ysum;
  logic [DATA_W-1:0] yq;
  logic [DATA_W-1:0] ylin2_r;
  logic [LOG_W-1:0]  delta2_r, ly12_r;
  logic              up2_r;

  always_comb begin
    ysum = {1'b0, yprod1_r} + 65'h80000000;
    yq   = ysum[63:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ylin2_r  <= neg1_r ? y11_r - yq : y11_r + yq;
      delta2_r <= full1_r ? diff1_r : dh1_r + LOG_W'(dl1_r[63:32]);
      up2_r    <= up1_r;
      ly12_r   <= ly11_r;
    end
  end

  // E3: blended log
  logic [LOG_W-1:0]    lb;
  logic [LOG_IW-1:0]   n3_r;
  logic [LOG_FRAC-1:0] f3_r;
  logic [DATA_W-1:0]   ylin3_r;

  assign lb = up2_r ? ly12_r + delta2_r : ly12_r - delta2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r    <= lb[LOG_W-1:LOG_FRAC];
      f3_r    <= lb[LOG_FRAC-1:0];
      ylin3_r <= ylin2_r;
    end
  end

  // E4/E5: w = f * ln2
  logic [63:0]       c00_r, c01_r, c10_r, c11_r;
  logic [LOG_IW-1:0] n4_r;
  logic [DATA_W-1:0] ylin4_r;
  logic [127:0]      wsum;
  ex_t               ex0_r;
  logic [63:0]       term0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c00_r   <= f3_r[31:0] * LN2_Q64[31:0];
      c01_r   <= f3_r[31:0] * LN2_Q64[63:32];
      c10_r   <= f3_r[LOG_FRAC-1:32] * LN2_Q64[31:0];
      c11_r   <= f3_r[LOG_FRAC-1:32] * LN2_Q64[63:32];
      n4_r    <= n3_r;
      ylin4_r <= ylin3_r;
    end
  end

  assign wsum = {c11_r, 64'b0} + {32'b0, c01_r, 32'b0} + {32'b0, c10_r, 32'b0}
              + {64'b0, c00_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ex0_r   <= '{n: n4_r, w: wsum[119:56], s: 64'b0, ylin: ylin4_r};
      term0_r <= wsum[119:56];
    end
  end

  // series terms
  ex_t         ex_in   [EXP_ITERS+1];
  logic [63:0] term_in [EXP_ITERS+1];

  assign ex_in[0]   = ex0_r;
  assign term_in[0] = term0_r;

  for (genvar j = 0; j < EXP_ITERS; j++) begin : g_term
    // floor(x/k) = (x + hi(x*MLO)) >> KL, with 2^64 + MLO = ceil(2^(64+KL)/k)
    localparam int          KV   = j + 2;
    localparam int          KL   = $clog2(KV);
    localparam logic [64:0] MREC = 65'(((128'd1 << (64 + KL)) + 128'(KV - 1)) / 128'(KV));
    localparam logic [63:0] MLO  = MREC[63:0];

    ex_t          exm_r;
    logic [63:0]  m00_r, m01_r, m10_r, m11_r;
    logic [127:0] msum;
    ex_t          exd_r  [RCP_STAGES+1];
    logic [63:0]  num_r  [RCP_STAGES];
    logic [63:0]  r00_r, r01_r, r10_r, r11_r;
    logic [127:0] rsum;
    logic [63:0]  ph_r;
    logic [64:0]  qsum;
    logic [63:0]  quo_r;

    always_ff @(posedge clk) begin
      if (en) begin
        exm_r   <= '{n: ex_in[j].n, w: ex_in[j].w, s: sat_add(ex_in[j].s, term_in[j]),
                     ylin: ex_in[j].ylin};
        m00_r   <= term_in[j][31:0] * ex_in[j].w[31:0];
        m01_r   <= term_in[j][31:0] * ex_in[j].w[63:32];
        m10_r   <= term_in[j][63:32] * ex_in[j].w[31:0];
        m11_r   <= term_in[j][63:32] * ex_in[j].w[63:32];
      end
    end

    assign msum = {m11_r, 64'b0} + {32'b0, m01_r, 32'b0} + {32'b0, m10_r, 32'b0}
                + {64'b0, m00_r};

    always_ff @(posedge clk) begin
      if (en) begin
        exd_r[0] <= exm_r;
        num_r[0] <= msum[127:64];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r00_r    <= num_r[0][31:0] * MLO[31:0];
        r01_r    <= num_r[0][31:0] * MLO[63:32];
        r10_r    <= num_r[0][63:32] * MLO[31:0];
        r11_r    <= num_r[0][63:32] * MLO[63:32];
        num_r[1] <= num_r[0];
        exd_r[1] <= exd_r[0];
      end
    end

    assign rsum = {r11_r, 64'b0} + {32'b0, r01_r, 32'b0} + {32'b0, r10_r, 32'b0}
                + {64'b0, r00_r};

    always_ff @(posedge clk) begin
      if (en) begin
        ph_r     <= rsum[127:64];
        num_r[2] <= num_r[1];
        exd_r[2] <= exd_r[1];
      end
    end

    assign qsum = {1'b0, num_r[2]} + {1'b0, ph_r};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r    <= 64'(qsum >> KL);
        exd_r[3] <= exd_r[2];
      end
    end

    assign ex_in[j+1]   = exd_r[RCP_STAGES];
    assign term_in[j+1] = quo_r;
  end

  // final add, scale and round
  ex_t         exf_r;
  logic [63:0] mant, shifted, vsum;
  logic [5:0]  shf;
  logic        sat_c;
  logic [DATA_W-1:0] yexp_r, ylin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      exf_r <= '{n: ex_in[EXP_ITERS].n, w: ex_in[EXP_ITERS].w,
                 s: sat_add(ex_in[EXP_ITERS].s, term_in[EXP_ITERS]),
                 ylin: ex_in[EXP_ITERS].ylin};
    end
  end

  always_comb begin
    mant    = {1'b1, exf_r.s[63:1]};
    shf     = 6'd62 - {1'b0, exf_r.n};
    shifted = mant >> shf;
    vsum    = {1'b0, shifted[63:1]} + {63'b0, shifted[0]};
    sat_c   = (exf_r.n > LOG_IW'(30)) || (vsum > 64'h7FFFFFFF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yexp_r <= sat_c ? 32'h7FFFFFFF : vsum[DATA_W-1:0];
      ylin_r <= exf_r.ylin;
    end
  end

  assign yexp = yexp_r;
  assign ylin = ylin_r;

endmodule

`default_nettype wire

>>> design/four_law_point_interpolator_unit.sv
// ----------------------------------------------------------------------------
// four_law_point_interpolator_unit: ENDF-style interpolation between two points
// Lin-lin, log-lin, lin-log, log-log and flat laws on signed Q16.16 values.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; every stage moves on the same enable, so
// a stalled output holds the whole pipe and the output register.
// Depth is set by the 56 squaring steps of the log lanes, the 32-step weight
// divider and the 24-term power series.
// Reset: synchronous, clears valid bits and sets the law register to lin-lin.
`default_nettype none

module four_law_point_interpolator_unit import fpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [2:0]               cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_query_x,
  input  logic signed [DATA_W-1:0] in_left_x,
  input  logic signed [DATA_W-1:0] in_left_y,
  input  logic signed [DATA_W-1:0] in_right_x,
  input  logic signed [DATA_W-1:0] in_right_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_y,
  output logic [1:0]               out_status_code
);

  logic [2:0] law_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      law_r <= LAW_LINLIN;
    end else if (cfg_wr_en) begin
      law_r <= cfg_wr_data;
    end
  end

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // front checks
  side_t           sd_nxt;
  logic [DATA_W:0] ysum, ymean;
  logic            x_pos, y_pos;

  always_comb begin
    ysum  = {in_left_y[DATA_W-1], in_left_y} + {in_right_y[DATA_W-1], in_right_y};
    ymean = ysum + {{DATA_W{1'b0}}, ysum[DATA_W]};
    x_pos = (in_query_x > 0) && (in_left_x > 0) && (in_right_x > 0);
    y_pos = (in_left_y > 0) && (in_right_y > 0);

    sd_nxt         = '0;
    sd_nxt.done    = 1'b1;
    sd_nxt.st      = ST_OK;
    sd_nxt.y1      = in_left_y;
    sd_nxt.y2      = in_right_y;
    sd_nxt.lin_a   = DATA_W'({in_query_x[DATA_W-1], in_query_x} - {in_left_x[DATA_W-1], in_left_x});
    sd_nxt.lin_d   = DATA_W'({in_right_x[DATA_W-1], in_right_x} - {in_left_x[DATA_W-1], in_left_x});

    if (law_r == LAW_OTHER) begin
      sd_nxt.st = ST_OTHER;
    end else if (in_left_x > in_right_x || in_query_x < in_left_x || in_query_x > in_right_x) begin
      sd_nxt.st = ST_INVALID;
    end else if (in_left_y == in_right_y) begin
      sd_nxt.spec_y = in_left_y;
    end else if (in_left_x == in_right_x) begin
      sd_nxt.spec_y = ymean[DATA_W:1];
    end else if (in_query_x == in_left_x) begin
      sd_nxt.spec_y = in_left_y;
    end else if (in_query_x == in_right_x) begin
      sd_nxt.spec_y = in_right_y;
    end else begin
      case (law_r)
        LAW_LINLIN: begin
          sd_nxt.done = 1'b0;
        end
        LAW_LOGLIN: begin
          if (!x_pos) sd_nxt.st = ST_INVALID;
          else begin
            sd_nxt.done   = 1'b0;
            sd_nxt.log_wt = 1'b1;
          end
        end
        LAW_LINLOG: begin
          if (!y_pos) sd_nxt.st = ST_INVALID;
          else begin
            sd_nxt.done    = 1'b0;
            sd_nxt.use_exp = 1'b1;
          end
        end
        LAW_LOGLOG: begin
          if (!x_pos || !y_pos) sd_nxt.st = ST_INVALID;
          else begin
            sd_nxt.done    = 1'b0;
            sd_nxt.log_wt  = 1'b1;
            sd_nxt.use_exp = 1'b1;
          end
        end
        LAW_FLAT: begin
          sd_nxt.spec_y = in_left_y;
        end
        default: begin
          sd_nxt.st = ST_INVALID;
        end
      endcase
    end
  end

  logic                            f_vld_r;
  side_t                           f_sd_r;
  logic [NUM_OPND-1:0][DATA_W-1:0] f_opnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_sd_r            <= sd_nxt;
      f_opnd_r[OPND_X]  <= in_query_x;
      f_opnd_r[OPND_X1] <= in_left_x;
      f_opnd_r[OPND_X2] <= in_right_x;
      f_opnd_r[OPND_Y1] <= in_left_y;
      f_opnd_r[OPND_Y2] <= in_right_y;
    end
  end

  logic                           l_vld;
  side_t                          l_sd;
  logic [NUM_OPND-1:0][LOG_W-1:0] lg;
  mid_t                           l_md;

  fpi_log_bank u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (f_vld_r),
    .sd_in   (f_sd_r),
    .opnd    (f_opnd_r),
    .vld_out (l_vld),
    .sd_out  (l_sd),
    .lg      (lg)
  );

  assign l_md = '{sd: l_sd, ly1: lg[OPND_Y1], ly2: lg[OPND_Y2]};

  logic            d_vld;
  mid_t            d_md;
  logic [WT_W-1:0] wt;

  fpi_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (l_vld),
    .md_in   (l_md),
    .lx      (lg[OPND_X]),
    .lx1     (lg[OPND_X1]),
    .lx2     (lg[OPND_X2]),
    .vld_out (d_vld),
    .md_out  (d_md),
    .wt      (wt)
  );

  logic                     e_vld;
  ctl_t                     e_ctl;
  logic signed [DATA_W-1:0] ylin;
  logic [DATA_W-1:0]        yexp;

  fpi_exp_unit u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (d_vld),
    .md_in   (d_md),
    .wt      (wt),
    .vld_out (e_vld),
    .ctl_out (e_ctl),
    .ylin    (ylin),
    .yexp    (yexp)
  );

  logic signed [DATA_W-1:0] out_y_r;
  status_t                  out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= e_ctl.st;
      out_y_r  <= e_ctl.done ? e_ctl.spec_y : (e_ctl.use_exp ? yexp : ylin);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_y    = out_y_r;
  assign out_status_code = out_st_r;

  // error status always carries a zero ordinate
  a_st_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_code != ST_OK |-> out_result_y == '0)
    else $error("nonzero result with error status");

  // the LAW_OTHER setting is flagged at the front stage
  a_other: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && law_r == LAW_OTHER |=> f_vld_r && f_sd_r.st == ST_OTHER)
    else $error("other law not flagged");

  // a stall freezes the front stage
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(f_vld_r) && $stable(f_sd_r))
    else $error("front stage moved during stall");

endmodule

`default_nettype wire

>>> dv/tb_four_law_point_interpolator_unit.sv
// ----------------------------------------------------------------------------
// tb_four_law_point_interpolator_unit: self-checking bench of the interpolator
// Drives bracketed and unbracketed query requests under every law setting, predicts each
// result with a bit-exact Q56 log/exp model and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_four_law_point_interpolator_unit;
  import fpi_pkg::*;

  typedef struct {
    logic signed [31:0] qx, lx, ly, rx, ry;
  } request_t;

  typedef struct {
    logic signed [31:0] y;
    logic [1:0]         st;
  } interp_result_t;

  // ---------------- bit-exact interpolation predictor ----------------
  class interp_scoreboard;
    logic [2:0]     law;
    interp_result_t pending[$];
    int             errors;
    int             checked;

    function automatic logic [63:0] log2_q56(logic [31:0] v);
      int          k;
      logic [63:0] z, acc;
      logic [127:0] sq;
      k = 0;
      acc = '0;
      if (v == 0) return '0;
      for (int i = 0; i < 32; i++) if (v[i]) k = i;
      z = {32'd0, v} << (63 - k);
      for (int i = 0; i < LOG_FRAC; i++) begin
        sq = {64'd0, z} * {64'd0, z};
        if (sq[127]) begin
          z = sq[127:64];
          acc = (acc << 1) | 64'd1;
        end else begin
          z = sq[126:63];
          acc = acc << 1;
        end
      end
      return (64'(k) << LOG_FRAC) | acc;
    endfunction

    function automatic logic [63:0] weight_q32(logic [63:0] a, logic [63:0] d);
      logic [63:0] r, q;
      r = a;
      q = '0;
      if (d == 0) return '0;
      if (a >= d) return 64'd1 << 32;
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function automatic logic [63:0] log_weight(logic [63:0] lq, logic [63:0] l1,
                                               logic [63:0] l2);
      return weight_q32(lq >= l1 ? lq - l1 : 64'd0, l2 >= l1 ? l2 - l1 : 64'd0);
    endfunction

    // delta rounds half away from zero; product wraps at 64 bits
    function automatic longint blend_y(longint y1, longint y2, logic [63:0] t);
      longint      dy;
      logic [63:0] mag, q;
      dy = y2 - y1;
      mag = dy < 0 ? 64'(-dy) : 64'(dy);
      q = (mag * t + (64'd1 << 31)) >> 32;
      return dy < 0 ? y1 - longint'(q) : y1 + longint'(q);
    endfunction

    function automatic logic [63:0] blend_log(logic [63:0] l1, logic [63:0] l2,
                                              logic [63:0] t);
      logic [127:0] p;
      logic         up;
      up = l2 >= l1;
      p = {64'd0, up ? l2 - l1 : l1 - l2} * {64'd0, t};
      return up ? l1 + p[95:32] : l1 - p[95:32];
    endfunction

    function automatic longint exp2_q56(logic [63:0] lv);
      logic [63:0]  n, f, w, term, s, mant, v, sum;
      logic [127:0] p;
      n = lv >> LOG_FRAC;
      f = lv & ((64'd1 << LOG_FRAC) - 1);
      s = '0;
      if (n > 30) return 64'h7FFFFFFF;
      p = {64'd0, f} * {64'd0, LN2_Q64};
      w = p[119:56];
      term = w;
      for (int k = 2; k <= EXP_TERMS + 1; k++) begin
        sum = s + term;
        s = (sum < s) ? '1 : sum;
        p = {64'd0, term} * {64'd0, w};
        term = p[127:64] / 64'(k);
      end
      mant = (64'd1 << 63) | (s >> 1);
      v = (mant >> (63 - n)) + ((mant >> (62 - n)) & 64'd1);
      if (v > 64'h7FFFFFFF) v = 64'h7FFFFFFF;
      return longint'(v);
    endfunction

    function automatic interp_result_t interpolate(request_t r);
      interp_result_t res;
      longint x, x1, x2, y1, y2, y;
      logic [1:0] st;
      logic [63:0] t;
      x = longint'(r.qx); x1 = longint'(r.lx); x2 = longint'(r.rx);
      y1 = longint'(r.ly); y2 = longint'(r.ry);
      y = 0;
      st = ST_OK;
      if (law == LAW_OTHER) st = ST_OTHER;
      else if (x1 > x2 || x < x1 || x > x2) st = ST_INVALID;
      else if (y1 == y2) y = y1;
      else if (x1 == x2) y = (y1 + y2) / 2;
      else if (x == x1) y = y1;
      else if (x == x2) y = y2;
      else begin
        case (law)
          LAW_LINLIN: y = blend_y(y1, y2, weight_q32(64'(x - x1), 64'(x2 - x1)));
          LAW_LOGLIN: begin
            if (x <= 0 || x1 <= 0 || x2 <= 0) st = ST_INVALID;
            else begin
              t = log_weight(log2_q56(32'(x)), log2_q56(32'(x1)), log2_q56(32'(x2)));
              y = blend_y(y1, y2, t);
            end
          end
          LAW_LINLOG: begin
            if (y1 <= 0 || y2 <= 0) st = ST_INVALID;
            else begin
              t = weight_q32(64'(x - x1), 64'(x2 - x1));
              y = exp2_q56(blend_log(log2_q56(32'(y1)), log2_q56(32'(y2)), t));
            end
          end
          LAW_LOGLOG: begin
            if (x <= 0 || x1 <= 0 || x2 <= 0 || y1 <= 0 || y2 <= 0) st = ST_INVALID;
            else begin
              t = log_weight(log2_q56(32'(x)), log2_q56(32'(x1)), log2_q56(32'(x2)));
              y = exp2_q56(blend_log(log2_q56(32'(y1)), log2_q56(32'(y2)), t));
            end
          end
          LAW_FLAT: y = y1;
          default:  st = ST_INVALID;
        endcase
      end
      if (st != ST_OK) y = 0;
      res.y = y[31:0];
      res.st = st;
      return res;
    endfunction

    function void note_request(request_t r);
      pending.push_back(interpolate(r));
    endfunction

    function void check_result(logic signed [31:0] y, logic [1:0] st);
      interp_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: y=%h status=%0d", $time, y, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (y !== e.y) begin
        $display("%0t: result_y mismatch: expected %h actual %h", $time, e.y, y);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status_code mismatch: expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_query_x, in_left_x, in_left_y, in_right_x, in_right_y;
  logic signed [31:0] out_result_y;
  logic [1:0] out_status_code;

  interp_scoreboard sb;
  bit quiet;        // no idling on either side
  int hold_cycles;  // receiver back-pressure request
  int sent;

  four_law_point_interpolator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_query_x(in_query_x), .in_left_x(in_left_x), .in_left_y(in_left_y),
    .in_right_x(in_right_x), .in_right_y(in_right_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_y(out_result_y), .out_status_code(out_status_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_ready <= quiet || ($urandom_range(99) >= 33);
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_result_y, out_status_code);

  task automatic set_law(logic [2:0] law);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= law;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.law = law;
  endtask

  task automatic send(request_t r);
    if (!quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_query_x <= r.qx; in_left_x <= r.lx; in_left_y <= r.ly;
    in_right_x <= r.rx; in_right_y <= r.ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick(bit pos);
    logic [31:0] v;
    v = $urandom;
    if (pos) begin
      v[31] = 1'b0;
      if ($urandom_range(3) == 0) v = v >> $urandom_range(31);
      if (v == 0) v = 1;
    end
    return v;
  endfunction

  function automatic request_t random_request(logic [2:0] law);
    request_t    r;
    longint      a, b, c, tmp, span;
    bit          posx, posy;
    logic [63:0] u;
    if ($urandom_range(99) < 20) begin
      r.qx = $urandom; r.lx = $urandom; r.ly = $urandom;
      r.rx = $urandom; r.ry = $urandom;
      return r;
    end
    posx = (law inside {LAW_LOGLIN, LAW_LOGLOG}) ? $urandom_range(99) < 90
                                                : $urandom_range(1);
    posy = (law inside {LAW_LINLOG, LAW_LOGLOG}) ? $urandom_range(99) < 90
                                                : $urandom_range(1);
    a = longint'(pick(posx));
    if ($urandom_range(99) < 30) begin
      b = a + longint'($urandom_range(0, 50));
      if (b > 64'sh7FFFFFFF) b = 64'sh7FFFFFFF;
    end else b = longint'(pick(posx));
    if (a > b) begin tmp = a; a = b; b = tmp; end
    span = b - a;
    u = {$urandom, $urandom};
    c = a + longint'(u % 64'(span + 1));
    case ($urandom_range(9))
      0: c = a;
      1: c = b;
      default: ;
    endcase
    r.lx = 32'(a); r.rx = 32'(b); r.qx = 32'(c);
    if ($urandom_range(19) == 0) begin
      r.ly = r.lx; r.lx = r.rx; r.rx = r.ly;
    end
    r.ly = pick(posy);
    r.ry = ($urandom_range(19) == 0) ? r.ly : pick(posy);
    return r;
  endfunction

  function automatic request_t mk(int qx, int lx, int ly, int rx, int ry);
    request_t r;
    r.qx = qx; r.lx = lx; r.ly = ly; r.rx = rx; r.ry = ry;
    return r;
  endfunction

  // corner requests: extremes, bad brackets, equal ordinates/abscissae,
  // ends, non-positive log operands, near-saturating growth
  task automatic directed;
    send(mk(32'sh00018000, 32'sh00010000, 32'sh00010000, 32'sh00020000, 32'sh00040000));
    send(mk(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
    send(mk(32'sh7FFFFFFE, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send(mk(5, 10, 1, 20, 2));
    send(mk(25, 10, 1, 20, 2));
    send(mk(15, 20, 1, 10, 2));
    send(mk(15, 10, 7, 20, 7));
    send(mk(10, 10, -3, 10, 6));
    send(mk(10, 10, 3, 20, 9));
    send(mk(20, 10, 3, 20, 9));
    send(mk(0, -10, 3, 20, 9));
    send(mk(15, 10, -3, 20, 9));
    send(mk(32'sh7FFFFFFE, 1, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
  endtask

  initial begin
    logic [2:0] plan[$] = '{LAW_LINLIN, LAW_LOGLIN, LAW_LINLOG, LAW_LOGLOG,
                            LAW_FLAT, LAW_OTHER, 3'd6, 3'd7, LAW_LOGLOG,
                            LAW_LINLOG, LAW_LOGLIN, LAW_LINLIN};
    sb = new();
    sb.law = LAW_LINLIN;
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; in_valid = 1'b0;
    in_query_x = '0; in_left_x = '0; in_left_y = '0; in_right_x = '0; in_right_y = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    drain();
    set_law(LAW_LOGLOG);
    directed();
    drain();
    foreach (plan[p]) begin
      set_law(plan[p]);
      for (int i = 0; i < 100; i++) begin
        quiet = (p == 3 && i >= 20 && i < 90);
        if (p == 0 && i == 30) hold_cycles = 800;
        send(random_request(plan[p]));
      end
      quiet = 1'b0;
      drain();
    end
    repeat (400) @(posedge clk);
    $display("covered %0d requests, %0d results checked, law settings 0..7",
             sent, sb.checked);
    $display("incl. bad brackets, degenerate brackets, end points and a long output stall");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

`default_nettype wire
